// ----- hw/rtl/cdq_pkg.sv -----
// Shared types and constants for the circular deque.
`default_nettype none

package cdq_pkg;

    // Number of entries and width of one stored value.
    localparam int DEPTH      = 8;
    localparam int DATA_WIDTH = 32;

    typedef logic signed [DATA_WIDTH-1:0] t_data;

    typedef enum logic [1:0] {
        MODE_PUSH_REAR  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- hw/rtl/cdq_if.sv -----
// Valid/ready channel interfaces for the deque request and result transactions.
`default_nettype none

interface cdq_in_if import cdq_pkg::*;;
    logic  valid;
    logic  ready;
    t_mode mode;
    t_data push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*;;
    logic    valid;
    logic    ready;
    t_data   data_out;
    t_status status;

    modport source (output valid, output data_out, output status, input ready);
    modport sink   (input valid, input data_out, input status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/circular_deque.sv -----
// Top level of the double-ended queue: a chain of entry cells and a result register.
// Output: a result is registered and appears the cycle after its request is taken.
// Throughput: one transaction per cycle; the single output register only stalls
// new requests while a result waits and the sink holds ready low.
// Reset: clears every cell's valid bit and the output valid flag, so the deque
// starts empty at once; stored values are not cleared and no clearing pass runs.
`default_nettype none

module circular_deque import cdq_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    cdq_in_if.sink    i_in,
    cdq_out_if.source o_out
);

    // Per-cell views of the chain. Entry 0 is always the front of the deque and
    // the valid bits are kept contiguous from entry 0, so the number of set bits
    // is the occupancy.
    t_data              w_cell_data [DEPTH];
    t_data              w_cell_rear [DEPTH];
    logic [DEPTH-1:0]   w_valid_vec;
    t_data              w_rear_data;
    t_data              w_front_data;
    logic               w_full;
    logic               w_empty;
    logic               w_accept;
    logic               w_is_push;
    t_cell_ctrl         w_ctrl;

    t_data              r_data_out;
    t_data              n_data_out;
    t_status            r_status;
    t_status            n_status;
    logic               r_out_valid;

    // The result register frees up when it is empty or its transaction completes,
    // so a new request is taken in the same cycle a result leaves.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_full       = w_valid_vec[DEPTH-1];
    assign w_empty      = !w_valid_vec[0];
    assign w_front_data = w_cell_data[0];
    assign w_is_push    = (i_in.mode == MODE_PUSH_REAR) || (i_in.mode == MODE_PUSH_FRONT);

    // The rear entry is the only cell that drives its rear output, so an OR over
    // all cells yields its value.
    always_comb begin
        w_rear_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rear_data = w_rear_data | w_cell_rear[k];
        end
    end

    // Decode the requested operation into the broadcast cell control. Refused
    // operations (push when full, pop when empty) leave the chain untouched.
    always_comb begin
        w_ctrl = '0;
        if (w_accept) begin
            case (i_in.mode)
                MODE_PUSH_REAR:  w_ctrl.push_rear  = !w_full;
                MODE_PUSH_FRONT: w_ctrl.push_front = !w_full;
                MODE_POP_FRONT:  w_ctrl.pop_front  = !w_empty;
                MODE_POP_REAR:   w_ctrl.pop_rear   = !w_empty;
                default:         w_ctrl = '0;
            endcase
        end
    end

    // Result of the request: a push echoes the stored value, a pop returns the
    // removed one, and a refused request reports its status with zero data.
    always_comb begin
        n_data_out = '0;
        n_status   = STATUS_OK;
        case (i_in.mode)
            MODE_PUSH_REAR, MODE_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    n_data_out = i_in.push_value;
                end
            end
            MODE_POP_FRONT: begin
                if (w_empty) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    n_data_out = w_front_data;
                end
            end
            MODE_POP_REAR: begin
                if (w_empty) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    n_data_out = w_rear_data;
                end
            end
            default: begin
                n_data_out = '0;
                n_status   = STATUS_OK;
            end
        endcase
    end

    // The chain of cells. The cell at the front sees the pushed value and a
    // valid left neighbor; the cell at the far end sees an empty right neighbor.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_data w_left_data;
        logic  w_left_valid;
        t_data w_right_data;
        logic  w_right_valid;

        if (g == 0) begin : g_first
            assign w_left_data  = i_in.push_value;
            assign w_left_valid = 1'b1;
        end else begin : g_inner_left
            assign w_left_data  = w_cell_data[g-1];
            assign w_left_valid = w_valid_vec[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_data  = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner_right
            assign w_right_data  = w_cell_data[g+1];
            assign w_right_valid = w_valid_vec[g+1];
        end

        cdq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_push_value  (i_in.push_value),
            .i_left_data   (w_left_data),
            .i_left_valid  (w_left_valid),
            .i_right_data  (w_right_data),
            .i_right_valid (w_right_valid),
            .o_data        (w_cell_data[g]),
            .o_valid       (w_valid_vec[g]),
            .o_rear_data   (w_cell_rear[g])
        );
    end

    // Output register: loads on every accepted request, drops its valid flag
    // once the result transaction completes with nothing new behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data_out <= n_data_out;
            r_status   <= n_status;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.data_out = r_data_out;
    assign o_out.status   = r_status;

    // The occupied cells always form one unbroken run starting at the front.
    a_valid_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid_vec & (w_valid_vec + 1'b1)) == '0)
        else $error("deque cells are not filled contiguously from the front");

    // Without an accepted request the occupancy of the chain never changes.
    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(w_valid_vec))
        else $error("deque occupancy changed without a request");

    // A push into a full deque reports full with zero data on the next result.
    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_push && w_full) |=>
            (o_out.status == STATUS_FULL && o_out.data_out == '0 && $stable(w_valid_vec)))
        else $error("push into a full deque was not refused");

    // A pop from a non-empty deque removes exactly one entry.
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_push && !w_empty) |=>
            ($countones(w_valid_vec) + 1 == $countones($past(w_valid_vec))))
        else $error("pop did not remove exactly one entry");

endmodule

`default_nettype wire

// ----- hw/rtl/cdq_cell.sv -----
// One entry of the deque chain; shifts toward either neighbor on front operations.
`default_nettype none

module cdq_cell import cdq_pkg::*; (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_data      i_push_value,
    input  wire t_data      i_left_data,
    input  wire             i_left_valid,
    input  wire t_data      i_right_data,
    input  wire             i_right_valid,
    output t_data           o_data,
    output logic            o_valid,
    output t_data           o_rear_data
);

    t_data r_data;
    t_data n_data;
    logic  r_valid;
    logic  n_valid;
    logic  w_is_rear;
    logic  w_is_next_free;

    // This cell holds the rear entry when it is valid and its right neighbor is not.
    assign w_is_rear      = r_valid && !i_right_valid;
    // This cell is the first free slot when it is empty and its left neighbor is full.
    assign w_is_next_free = !r_valid && i_left_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctrl.push_front) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_ctrl.pop_front) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_ctrl.push_rear && w_is_next_free) begin
            n_data  = i_push_value;
            n_valid = 1'b1;
        end else if (i_ctrl.pop_rear && w_is_rear) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_valid     = r_valid;
    assign o_rear_data = w_is_rear ? r_data : '0;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the circular deque: directed and random request traffic against a built-in predictor.

module tb_top;
    import cdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One request and one reply as seen on the two channels.
    typedef struct {
        t_mode mode;
        t_data value;
    } t_request;

    typedef struct {
        t_data   data;
        t_status status;
    } t_reply;

    // The run should finish far below this, even in the slowest correct run with both sides
    // idling heavily and the long hold-off.
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_PER_PHASE = 288;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cdq_in_if  in_if();
    cdq_out_if out_if();

    circular_deque uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Requests waiting for the driver, and replies the predictor says must come back.
    t_request request_queue[$];
    t_reply   expected_replies[$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Idle rates in percent. The initial block changes them between phases.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Long receiver hold-off. The initial block raises holding; the cycles are
    // counted in their own process below.
    logic holding  = 1'b0;
    int   hold_cnt = 0;

    // Set at each rising edge when the request in flight was accepted, so the driver
    // at the next falling edge knows whether it may move on.
    logic req_taken = 1'b0;

    // Predictor state: a mirror of the deque contents.
    t_data model_slots[DEPTH];
    int    model_head  = 0;
    int    model_tail  = 0;
    logic  model_empty = 1'b1;

    // Computes the reply to one request and updates the mirror of the deque. A push
    // into an empty deque always lands in slot zero, whichever end it names, and
    // taking out the last entry returns both indices to zero.
    function automatic t_reply deque_predict(t_request req);
        t_reply rep;
        logic   full;
        rep.data   = '0;
        rep.status = STATUS_OK;
        full = !model_empty && ((model_tail + 1) % DEPTH == model_head);
        case (req.mode)
            MODE_PUSH_REAR, MODE_PUSH_FRONT: begin
                if (full) begin
                    rep.status = STATUS_FULL;
                end else begin
                    if (model_empty) begin
                        model_head     = 0;
                        model_tail     = 0;
                        model_empty    = 1'b0;
                        model_slots[0] = req.value;
                    end else if (req.mode == MODE_PUSH_REAR) begin
                        model_tail = (model_tail + 1) % DEPTH;
                        model_slots[model_tail] = req.value;
                    end else begin
                        model_head = (model_head + DEPTH - 1) % DEPTH;
                        model_slots[model_head] = req.value;
                    end
                    rep.data = req.value;
                end
            end
            default: begin
                if (model_empty) begin
                    rep.status = STATUS_EMPTY;
                end else if (model_head == model_tail) begin
                    rep.data    = model_slots[model_head];
                    model_empty = 1'b1;
                    model_head  = 0;
                    model_tail  = 0;
                end else if (req.mode == MODE_POP_FRONT) begin
                    rep.data   = model_slots[model_head];
                    model_head = (model_head + 1) % DEPTH;
                end else begin
                    rep.data   = model_slots[model_tail];
                    model_tail = (model_tail + DEPTH - 1) % DEPTH;
                end
            end
        endcase
        return rep;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Push values lean on the extremes now and then; otherwise any 32-bit pattern.
    function automatic t_data pick_value();
        case ($urandom_range(15))
            0:       return t_data'(32'h8000_0000);
            1:       return t_data'(32'h7FFF_FFFF);
            2:       return '0;
            3:       return '1;
            default: return t_data'($urandom);
        endcase
    endfunction

    task automatic queue_request(t_mode mode, t_data value);
        t_request req;
        req.mode  = mode;
        req.value = value;
        request_queue.push_back(req);
    endtask

    // Random traffic in bursts. Each burst leans toward pushes, pops or neither,
    // so the deque keeps swinging between empty and full and the indices wrap
    // in both directions. Pops carry random values too, since they must be ignored.
    task automatic queue_random_traffic(int count);
        int burst_left;
        int push_pct;
        burst_left = 0;
        push_pct   = 50;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(8, 40);
                case ($urandom_range(2))
                    0:       push_pct = 20;
                    1:       push_pct = 50;
                    default: push_pct = 80;
                endcase
            end
            burst_left--;
            if ($urandom_range(99) < push_pct) begin
                queue_request(t_mode'($urandom_range(1)), pick_value());
            end else begin
                queue_request(t_mode'($urandom_range(3, 2)), t_data'($urandom));
            end
        end
    endtask

    // Directed opening: pops on an empty deque, a push at the front of an empty
    // deque, removal of the only entry, a fill to capacity with extreme and
    // alternating-bit values from both ends, refused pushes at both ends, and a
    // drain from both ends down to empty and one step beyond.
    task automatic queue_directed();
        queue_request(MODE_POP_FRONT, t_data'(32'h1234_5678));
        queue_request(MODE_POP_REAR, t_data'(32'hFFFF_FFFF));
        queue_request(MODE_PUSH_FRONT, t_data'(32'h8000_0000));
        queue_request(MODE_POP_REAR, '0);
        queue_request(MODE_PUSH_REAR, t_data'(32'h7FFF_FFFF));
        queue_request(MODE_PUSH_FRONT, t_data'(32'hFFFF_FFFF));
        queue_request(MODE_PUSH_REAR, t_data'(32'h0000_0000));
        queue_request(MODE_PUSH_FRONT, t_data'(32'h0000_0001));
        queue_request(MODE_PUSH_REAR, t_data'(32'h5555_5555));
        queue_request(MODE_PUSH_FRONT, t_data'(32'hAAAA_AAAA));
        queue_request(MODE_PUSH_REAR, t_data'(32'h8000_0000));
        queue_request(MODE_PUSH_FRONT, t_data'(32'h0F0F_F0F0));
        queue_request(MODE_PUSH_REAR, t_data'(32'h1111_1111));
        queue_request(MODE_PUSH_FRONT, t_data'(32'h2222_2222));
        queue_request(MODE_POP_FRONT, '0);
        queue_request(MODE_POP_REAR, '0);
        queue_request(MODE_POP_FRONT, '0);
        queue_request(MODE_POP_REAR, '0);
        queue_request(MODE_POP_FRONT, '0);
        queue_request(MODE_POP_REAR, '0);
        queue_request(MODE_POP_FRONT, '0);
        queue_request(MODE_POP_REAR, '0);
        queue_request(MODE_POP_FRONT, '0);
    endtask

    task automatic wait_for_quiet();
        while (request_queue.size() != 0 || expected_replies.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Request driver. It changes its outputs only at the falling edge and moves to a
    // new transaction only once the one on the bus has been accepted. Each signal
    // gets exactly one assignment per falling edge.
    always @(negedge i_clk) begin
        t_request req;
        logic     next_valid;
        t_mode    next_mode;
        t_data    next_value;
        next_valid = in_if.valid;
        next_mode  = in_if.mode;
        next_value = in_if.push_value;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!in_if.valid || req_taken) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req        = request_queue.pop_front();
                next_valid = 1'b1;
                next_mode  = req.mode;
                next_value = req.value;
            end else begin
                next_valid = 1'b0;
            end
        end
        in_if.valid      = next_valid;
        in_if.mode       = next_mode;
        in_if.push_value = next_value;
    end

    // Reply receiver. Ready drops at random, and stays low through a hold-off so
    // that the result register fills and the deque pushes back on its input.
    always @(negedge i_clk) begin
        out_if.ready = i_rst_n && !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!holding) begin
            hold_cnt <= 0;
        end else begin
            hold_cnt <= hold_cnt + 1;
        end
    end

    // Monitor. The reply check comes before the prediction of a request accepted
    // at the same edge, because that reply belongs to an earlier request.
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            req_taken = 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch($sformatf("reply with none pending: data %0d status %0d",
                        out_if.data_out, out_if.status));
                end else begin
                    want = expected_replies.pop_front();
                    if (out_if.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, predicted %0d",
                            out_if.status, want.status));
                    end
                    if (out_if.data_out !== want.data) begin
                        report_mismatch($sformatf("data_out %0d, predicted %0d",
                            out_if.data_out, want.data));
                    end
                end
            end
            req_taken = in_if.valid && in_if.ready;
            if (req_taken) begin
                expected_replies.push_back(deque_predict('{in_if.mode, in_if.push_value}));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Sequencer: reset, then four phases of traffic with different idle patterns.
    initial begin
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.mode       = MODE_PUSH_REAR;
        in_if.push_value = '0;
        out_if.ready     = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Phase one: no idling on either side, with the long hold-off at its start
        // while the driver keeps offering transactions.
        queue_directed();
        queue_random_traffic(RANDOM_PER_PHASE);
        holding = 1'b1;
        while (hold_cnt < HOLD_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        holding = 1'b0;
        wait_for_quiet();

        // Phase two: the sender idles most of the time.
        @(negedge i_clk);
        send_idle_pct  = 74;
        recv_stall_pct = 0;
        queue_random_traffic(RANDOM_PER_PHASE);
        wait_for_quiet();

        // Phase three: the receiver stalls most of the time.
        @(negedge i_clk);
        send_idle_pct  = 0;
        recv_stall_pct = 74;
        queue_random_traffic(RANDOM_PER_PHASE);
        wait_for_quiet();

        // Phase four: both sides idle a third of the time.
        @(negedge i_clk);
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        queue_random_traffic(RANDOM_PER_PHASE);
        wait_for_quiet();

        // Let the clock run on so that any stray reply is caught by the monitor.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- circular_deque.f -----
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_if.sv
hw/rtl/cdq_cell.sv
hw/rtl/circular_deque.sv
verif/tb_top.sv
